### design/height_to_normal_map_macros.svh
// Assertion helpers for the design files; hnm_back uses them.
`ifndef HEIGHT_TO_NORMAL_MAP_MACROS_SVH
`define HEIGHT_TO_NORMAL_MAP_MACROS_SVH

// Checked on every clock edge outside reset.
`define HNM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define HNM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### design/hnm_pkg.sv
`default_nettype none
package hnm_pkg;

   localparam int MAX_WIDTH_DEFAULT   = 4096;
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH         = 4;

   // configuration register indexes
   localparam logic [1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_HEIGHT_SCALE   = 2'd1;
   localparam logic [1:0] CSR_SLOPE_STRENGTH = 2'd2;
   localparam logic [1:0] CSR_INVERT_Y       = 2'd3;

   // input command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_DRAIN  = 1'b1;

   // one pixel's neighborhood, handed from front to back
   typedef struct packed {
      logic [15:0] hl;
      logic [15:0] hr;
      logic [15:0] hd;
      logic [15:0] hu;
      logic [11:0] col;
      logic        row_end;
      logic        frame_end;
   } task_type;

   typedef struct packed {
      logic [15:0] height_scale;
      logic [15:0] slope_strength;
      logic        invert_y;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [11:0] pixel_col;
      logic        row_end;
      logic        frame_end;
   } result_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_RD_L,
      F_RD_R,
      F_RD_C,
      F_CAP,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_GAIN,
      B_PROD,
      B_NORM,
      B_SQR,
      B_SUM,
      B_SQRT,
      B_DSET,
      B_DIV,
      B_OUT
   } back_state_type;

endpackage
`default_nettype wire

### design/hnm_front.sv
`default_nettype none
module hnm_front #(
   parameter int MAX_WIDTH   = hnm_pkg::MAX_WIDTH_DEFAULT,
   parameter int SAMPLE_BITS = hnm_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [12:0]       image_width,
   input  wire logic              req_push,
   input  wire logic              req_cmd,
   input  wire logic [15:0]       req_height_sample,
   output logic                   req_full,
   input  wire logic              q_full,
   output logic                   q_push,
   output hnm_pkg::task_type      q_data
);

   localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;

   hnm_pkg::front_state_type state_ff, state_in;

   logic [IW-1:0] col_cnt_ff, col_cnt_in;
   logic [IW-1:0] drain_cnt_ff, drain_cnt_in;
   logic [1:0]    rows_seen_ff, rows_seen_in;
   logic          bank_ff, bank_in;

   logic          cmd_ff, cmd_in;
   logic [HW-1:0] h_ff, h_in;
   logic [IW-1:0] x_ff, x_in;
   logic [IW-1:0] xl_ff, xl_in;
   logic [IW-1:0] xr_ff, xr_in;
   logic          last_ff, last_in;
   logic [HW-1:0] hl_ff, hl_in;
   logic [HW-1:0] hr_ff, hr_in;
   logic [HW-1:0] hdo_ff, hdo_in;
   logic [HW-1:0] hc_ff, hc_in;

   logic [HW-1:0] older_row_mem [MAX_WIDTH];
   logic [HW-1:0] newer_row_mem [MAX_WIDTH];
   logic [HW-1:0] q_older_ff, q_newer_ff;

   logic [WW-1:0] w_eff;
   logic [IW-1:0] cnt_sel, x_acc;
   logic          last_acc;
   logic [HW-1:0] h_new;
   logic [IW-1:0] nb_addr, ob_addr, wr_addr;
   logic [IW-1:0] addr_older, addr_newer;
   logic [HW-1:0] nb_q, ob_q, wr_data;
   logic          we_ob;

   always_comb begin
      if (image_width == 13'd0) begin
         w_eff = WW'(1);
      end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(image_width);
      end
   end

   assign h_new    = HW'(req_height_sample);
   assign cnt_sel  = (req_cmd == hnm_pkg::CMD_DRAIN) ? drain_cnt_ff : col_cnt_ff;
   assign x_acc    = (WW'(cnt_sel) < w_eff) ? cnt_sel : IW'(w_eff - WW'(1));
   assign last_acc = (WW'(x_acc) == w_eff - WW'(1));

   // bank_ff swaps which physical store plays the newer row
   assign addr_older = bank_ff ? nb_addr : ob_addr;
   assign addr_newer = bank_ff ? ob_addr : nb_addr;
   assign nb_q       = bank_ff ? q_older_ff : q_newer_ff;
   assign ob_q       = bank_ff ? q_newer_ff : q_older_ff;

   always_comb begin
      state_in     = state_ff;
      col_cnt_in   = col_cnt_ff;
      drain_cnt_in = drain_cnt_ff;
      rows_seen_in = rows_seen_ff;
      bank_in      = bank_ff;
      cmd_in       = cmd_ff;
      h_in         = h_ff;
      x_in         = x_ff;
      xl_in        = xl_ff;
      xr_in        = xr_ff;
      last_in      = last_ff;
      hl_in        = hl_ff;
      hr_in        = hr_ff;
      hdo_in       = hdo_ff;
      hc_in        = hc_ff;
      nb_addr      = x_ff;
      ob_addr      = x_ff;
      wr_addr      = x_ff;
      wr_data      = h_ff;
      we_ob        = 1'b0;
      q_push       = 1'b0;

      case (state_ff)
         hnm_pkg::F_IDLE: begin
            if (req_push) begin
               cmd_in  = req_cmd;
               h_in    = h_new;
               x_in    = x_acc;
               last_in = last_acc;
               xl_in   = (x_acc == '0) ? x_acc : x_acc - IW'(1);
               xr_in   = (WW'(x_acc) + WW'(1) < w_eff) ? x_acc + IW'(1) : x_acc;
               if (rows_seen_ff != 2'd0) begin
                  state_in = hnm_pkg::F_RD_L;
               end else if (req_cmd == hnm_pkg::CMD_DRAIN) begin
                  // nothing buffered yet: just restart the counters
                  col_cnt_in   = '0;
                  drain_cnt_in = '0;
               end else begin
                  we_ob   = 1'b1;
                  wr_addr = x_acc;
                  wr_data = h_new;
                  if (last_acc) begin
                     col_cnt_in   = '0;
                     bank_in      = ~bank_ff;
                     rows_seen_in = rows_seen_ff + 2'd1;
                  end else begin
                     col_cnt_in = x_acc + IW'(1);
                  end
               end
            end
         end
         hnm_pkg::F_RD_L: begin
            nb_addr  = xl_ff;
            state_in = hnm_pkg::F_RD_R;
         end
         hnm_pkg::F_RD_R: begin
            nb_addr  = xr_ff;
            hl_in    = nb_q;
            hdo_in   = ob_q;
            state_in = hnm_pkg::F_RD_C;
         end
         hnm_pkg::F_RD_C: begin
            hr_in    = nb_q;
            state_in = hnm_pkg::F_CAP;
         end
         hnm_pkg::F_CAP: begin
            hc_in    = nb_q;
            state_in = hnm_pkg::F_PUSH;
         end
         hnm_pkg::F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = hnm_pkg::F_IDLE;
               if (cmd_ff == hnm_pkg::CMD_SAMPLE) begin
                  we_ob = 1'b1;
                  if (last_ff) begin
                     col_cnt_in = '0;
                     bank_in    = ~bank_ff;
                     if (rows_seen_ff != 2'd2) begin
                        rows_seen_in = rows_seen_ff + 2'd1;
                     end
                  end else begin
                     col_cnt_in = x_ff + IW'(1);
                  end
               end else if (last_ff) begin
                  col_cnt_in   = '0;
                  drain_cnt_in = '0;
                  rows_seen_in = 2'd0;
                  bank_in      = 1'b0;
               end else begin
                  drain_cnt_in = x_ff + IW'(1);
               end
            end
         end
         default: begin
            state_in = hnm_pkg::F_IDLE;
         end
      endcase
   end

   always_comb begin
      q_data.hl        = 16'(hl_ff);
      q_data.hr        = 16'(hr_ff);
      q_data.hd        = (rows_seen_ff == 2'd2) ? 16'(hdo_ff) : 16'(hc_ff);
      q_data.hu        = (cmd_ff == hnm_pkg::CMD_DRAIN) ? 16'(hc_ff) : 16'(h_ff);
      q_data.col       = 12'(x_ff);
      q_data.row_end   = last_ff;
      q_data.frame_end = (cmd_ff == hnm_pkg::CMD_DRAIN) && last_ff;
   end

   assign req_full = (state_ff != hnm_pkg::F_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hnm_pkg::F_IDLE;
         col_cnt_ff   <= '0;
         drain_cnt_ff <= '0;
         rows_seen_ff <= 2'd0;
         bank_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_cnt_ff   <= col_cnt_in;
         drain_cnt_ff <= drain_cnt_in;
         rows_seen_ff <= rows_seen_in;
         bank_ff      <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      h_ff    <= h_in;
      x_ff    <= x_in;
      xl_ff   <= xl_in;
      xr_ff   <= xr_in;
      last_ff <= last_in;
      hl_ff   <= hl_in;
      hr_ff   <= hr_in;
      hdo_ff  <= hdo_in;
      hc_ff   <= hc_in;
   end

   always_ff @(posedge clock) begin
      if (we_ob && !bank_ff) begin
         older_row_mem[wr_addr] <= wr_data;
      end
      q_older_ff <= older_row_mem[addr_older];
   end

   always_ff @(posedge clock) begin
      if (we_ob && bank_ff) begin
         newer_row_mem[wr_addr] <= wr_data;
      end
      q_newer_ff <= newer_row_mem[addr_newer];
   end

endmodule
`default_nettype wire

### design/hnm_queue.sv
`default_nettype none
module hnm_queue #(
   parameter int DEPTH = hnm_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire hnm_pkg::task_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output hnm_pkg::task_type      pop_data,
   output logic                   empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   hnm_pkg::task_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### design/hnm_back.sv
`default_nettype none
`include "height_to_normal_map_macros.svh"
module hnm_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hnm_pkg::cfg_type    cfg,
   input  wire logic                q_empty,
   input  wire hnm_pkg::task_type   q_data,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output hnm_pkg::result_type      rsp_data
);

   hnm_pkg::back_state_type state_ff, state_in;

   logic [15:0] da_ff, da_in;
   logic [15:0] db_ff, db_in;
   logic        nega_ff, nega_in;
   logic        negb_ff, negb_in;
   logic [11:0] col_ff, col_in;
   logic        rend_ff, rend_in;
   logic        fend_ff, fend_in;
   logic [31:0] gain_ff, gain_in;
   logic [47:0] a_ff, a_in;
   logic [47:0] b_ff, b_in;
   logic [16:0] d_ff, d_in;
   logic [45:0] sa_ff, sa_in;
   logic [45:0] sb_ff, sb_in;
   logic [45:0] sd_ff, sd_in;
   logic [47:0] v_ff, v_in;
   logic [47:0] r_ff, r_in;
   logic [47:0] bit_ff, bit_in;
   logic [1:0]  comp_ff, comp_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [33:0] rem_ff, rem_in;
   logic [33:0] den_ff, den_in;
   logic [7:0]  q_ff, q_in;
   logic [7:0]  red_ff, red_in;
   logic [7:0]  green_ff, green_in;
   logic [7:0]  blue_ff, blue_in;

   hnm_pkg::result_type out_ff, out_in;
   logic                out_valid_ff, out_valid_in;
   logic                out_load;

   logic [23:0] len;
   logic [22:0] mag;
   logic        neg;
   logic [24:0] t;
   logic [47:0] r_plus_bit;
   logic        qbit;

   assign len        = r_ff[23:0];
   assign r_plus_bit = r_ff + bit_ff;
   assign qbit       = (rem_ff >= den_ff);

   always_comb begin
      case (comp_ff)
         2'd0: begin
            mag = a_ff[22:0];
            neg = nega_ff;
         end
         2'd1: begin
            mag = b_ff[22:0];
            neg = negb_ff ^ cfg.invert_y;
         end
         default: begin
            mag = 23'(d_ff);
            neg = 1'b0;
         end
      endcase
      t = neg ? (25'(len) - 25'(mag)) : (25'(len) + 25'(mag));
   end

   always_comb begin
      state_in     = state_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      nega_in      = nega_ff;
      negb_in      = negb_ff;
      col_in       = col_ff;
      rend_in      = rend_ff;
      fend_in      = fend_ff;
      gain_in      = gain_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      d_in         = d_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      sd_in        = sd_ff;
      v_in         = v_ff;
      r_in         = r_ff;
      bit_in       = bit_ff;
      comp_in      = comp_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      q_in         = q_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      out_in       = out_ff;
      out_load     = 1'b0;
      q_pop        = 1'b0;

      case (state_ff)
         hnm_pkg::B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               da_in    = (q_data.hr >= q_data.hl) ? q_data.hr - q_data.hl
                                                   : q_data.hl - q_data.hr;
               db_in    = (q_data.hu >= q_data.hd) ? q_data.hu - q_data.hd
                                                   : q_data.hd - q_data.hu;
               nega_in  = (q_data.hr > q_data.hl);
               negb_in  = (q_data.hu > q_data.hd);
               col_in   = q_data.col;
               rend_in  = q_data.row_end;
               fend_in  = q_data.frame_end;
               state_in = hnm_pkg::B_GAIN;
            end
         end
         hnm_pkg::B_GAIN: begin
            gain_in  = 32'(cfg.height_scale) * 32'(cfg.slope_strength);
            state_in = hnm_pkg::B_PROD;
         end
         hnm_pkg::B_PROD: begin
            a_in     = 48'(da_ff) * 48'(gain_ff);
            b_in     = 48'(db_ff) * 48'(gain_ff);
            d_in     = 17'h10000;
            state_in = hnm_pkg::B_NORM;
         end
         hnm_pkg::B_NORM: begin
            // common right shift, one bit a cycle, until all fit in 23 bits
            if ((a_ff[47:23] != '0) || (b_ff[47:23] != '0)) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               d_in = d_ff >> 1;
            end else begin
               state_in = hnm_pkg::B_SQR;
            end
         end
         hnm_pkg::B_SQR: begin
            sa_in    = 46'(a_ff[22:0]) * 46'(a_ff[22:0]);
            sb_in    = 46'(b_ff[22:0]) * 46'(b_ff[22:0]);
            sd_in    = 46'(d_ff) * 46'(d_ff);
            state_in = hnm_pkg::B_SUM;
         end
         hnm_pkg::B_SUM: begin
            v_in     = 48'(sa_ff) + 48'(sb_ff) + 48'(sd_ff);
            r_in     = '0;
            bit_in   = 48'(1) << 46;
            state_in = hnm_pkg::B_SQRT;
         end
         hnm_pkg::B_SQRT: begin
            // two radicand bits per cycle
            if (v_ff >= r_plus_bit) begin
               v_in = v_ff - r_plus_bit;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               comp_in  = 2'd0;
               state_in = hnm_pkg::B_DSET;
            end
         end
         hnm_pkg::B_DSET: begin
            // (255*t + L) / (2L); quotient stays below 256
            rem_in   = (34'(t) << 8) - 34'(t) + 34'(len);
            den_in   = 34'(len) << 8;
            cnt_in   = 3'd0;
            q_in     = 8'd0;
            state_in = hnm_pkg::B_DIV;
         end
         hnm_pkg::B_DIV: begin
            if (qbit) begin
               rem_in = rem_ff - den_ff;
            end
            den_in = den_ff >> 1;
            q_in   = {q_ff[6:0], qbit};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               case (comp_ff)
                  2'd0:    red_in   = {q_ff[6:0], qbit};
                  2'd1:    green_in = {q_ff[6:0], qbit};
                  default: blue_in  = {q_ff[6:0], qbit};
               endcase
               if (comp_ff == 2'd2) begin
                  state_in = hnm_pkg::B_OUT;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = hnm_pkg::B_DSET;
               end
            end
         end
         hnm_pkg::B_OUT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_load         = 1'b1;
               out_in.red       = red_ff;
               out_in.green     = green_ff;
               out_in.blue      = blue_ff;
               out_in.pixel_col = col_ff;
               out_in.row_end   = rend_ff;
               out_in.frame_end = fend_ff;
               state_in         = hnm_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = hnm_pkg::B_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hnm_pkg::B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      da_ff    <= da_in;
      db_ff    <= db_in;
      nega_ff  <= nega_in;
      negb_ff  <= negb_in;
      col_ff   <= col_in;
      rend_ff  <= rend_in;
      fend_ff  <= fend_in;
      gain_ff  <= gain_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      d_ff     <= d_in;
      sa_ff    <= sa_in;
      sb_ff    <= sb_in;
      sd_ff    <= sd_in;
      v_ff     <= v_in;
      r_ff     <= r_in;
      bit_ff   <= bit_in;
      comp_ff  <= comp_in;
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      q_ff     <= q_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      out_ff   <= out_in;
   end

   `HNM_ASSERT(a_pop_only_idle, q_pop |-> (state_ff == hnm_pkg::B_IDLE), "queue popped while busy")
   `HNM_ASSERT(a_len_nonzero, (state_ff == hnm_pkg::B_DSET) |-> (len != '0), "zero vector length")
   `HNM_ASSERT(a_load_free, out_load |-> (!out_valid_ff || rsp_pop), "result overwritten")
   `HNM_ASSERT_ALWAYS(a_reset_idle, (!reset && $past(reset)) |-> (state_ff == hnm_pkg::B_IDLE), "not idle after reset")

endmodule
`default_nettype wire

### design/height_to_normal_map.sv
// Height field to normal map, streaming.
// Input queue port: push a transaction (req_cmd, req_height_sample) whenever
// req_full is low. req_cmd selects a raster-order height sample or a drain
// transaction; after the last row, image_width drains flush that row.
// Result queue port: while rsp_empty is low, rsp_red/green/blue plus
// rsp_pixel_col, rsp_row_end and rsp_frame_end hold the oldest result; it
// leaves on a cycle with rsp_pop high. A stalled receiver only holds the
// result register; the front keeps taking samples until the 4-entry task
// queue fills, then req_full stays high.
// Timing: a transaction that yields a pixel keeps the front busy in F_RD_L,
// F_RD_R, F_RD_C, F_CAP and F_PUSH (four line-store reads through one read
// port per store); the back takes one pixel at a time through the one-bit
// normalize shift (up to 25), the 24-step square root and three 8-step
// dividers. Transactions with no pixel (first row) are taken one per cycle.
// Configuration: csr_write with csr_index and csr_wdata, only while idle.
// Reset (synchronous, active high) clears counters, queue and result flag;
// the line stores are not cleared and need no clearing pass.
`default_nettype none
module height_to_normal_map #(
   parameter int MAX_WIDTH   = hnm_pkg::MAX_WIDTH_DEFAULT,
   parameter int SAMPLE_BITS = hnm_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_cmd,
   input  wire logic [15:0] req_height_sample,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [11:0]      rsp_pixel_col,
   output logic             rsp_row_end,
   output logic             rsp_frame_end,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   // configuration registers
   logic [12:0]      image_width_ff;
   hnm_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff        <= 13'd256;
         cfg_ff.height_scale   <= 16'd256;
         cfg_ff.slope_strength <= 16'd256;
         cfg_ff.invert_y       <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            hnm_pkg::CSR_IMAGE_WIDTH:    image_width_ff        <= csr_wdata[12:0];
            hnm_pkg::CSR_HEIGHT_SCALE:   cfg_ff.height_scale   <= csr_wdata;
            hnm_pkg::CSR_SLOPE_STRENGTH: cfg_ff.slope_strength <= csr_wdata;
            hnm_pkg::CSR_INVERT_Y:       cfg_ff.invert_y       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // front: line stores and raster counters
   hnm_pkg::task_type   push_task, pop_task;
   hnm_pkg::result_type result;
   logic                q_push, q_full, q_pop, q_empty;

   hnm_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .image_width       (image_width_ff),
      .req_push          (req_push),
      .req_cmd           (req_cmd),
      .req_height_sample (req_height_sample),
      .req_full          (req_full),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_data            (push_task)
   );

   // decouples the front from the long normal computation
   hnm_queue #(
      .DEPTH (hnm_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_task),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_task),
      .empty     (q_empty)
   );

   // back: gain, normalize, square root, component mapping
   hnm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_data    (pop_task),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (result)
   );

   assign rsp_red       = result.red;
   assign rsp_green     = result.green;
   assign rsp_blue      = result.blue;
   assign rsp_pixel_col = result.pixel_col;
   assign rsp_row_end   = result.row_end;
   assign rsp_frame_end = result.frame_end;

endmodule
`default_nettype wire
